>>> sv/u8dec_pkg.sv
// Package: types, constants and helpers for the lenient UTF-8 stream decoder.
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned USED_W = 3;
  localparam int unsigned PAY_W  = 6;
  localparam int unsigned MAX_RES = 4;

  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hc0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
  localparam logic [PAY_W-1:0]  PAY_MASK  = 6'h3f;
  localparam logic [4:0]        LEAD2_MASK = 5'h1f;
  localparam logic [3:0]        LEAD3_MASK = 4'h0f;
  localparam logic [2:0]        LEAD4_MASK = 3'h07;

  localparam logic [USED_W-1:0] LEN_1 = 3'd1;
  localparam logic [USED_W-1:0] LEN_2 = 3'd2;
  localparam logic [USED_W-1:0] LEN_3 = 3'd3;
  localparam logic [USED_W-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0]   codepoint;
    logic [USED_W-1:0] bytes_used;
    logic              run_end;
    logic              string_end;
  } res_t;

  function automatic logic [USED_W-1:0] claim_of(input logic [BYTE_W-1:0] b);
    logic [USED_W-1:0] len;
    len = LEN_1;
    if (b >= 8'hc0 && b <= 8'hdf) len = LEN_2;
    else if (b >= 8'he0 && b <= 8'hef) len = LEN_3;
    else if (b >= 8'hf0 && b <= 8'hf7) len = LEN_4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic res_t raw_res(input logic [BYTE_W-1:0] b);
    res_t r;
    r.codepoint  = {{(CP_W-BYTE_W){1'b0}}, b};
    r.bytes_used = LEN_1;
    r.run_end    = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/u8dec_if.sv
// Interfaces: byte input channel and codepoint result channel.
interface u8dec_in_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              string_last;

  modport source (output valid, in_byte, string_last, input ready);
  modport sink   (input valid, in_byte, string_last, output ready);
endinterface

interface u8dec_out_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   codepoint;
  logic [USED_W-1:0] bytes_used;
  logic              run_end;
  logic              string_end;

  modport source (output valid, codepoint, bytes_used, run_end, string_end, input ready);
  modport sink   (input valid, codepoint, bytes_used, run_end, string_end, output ready);
endinterface

>>> sv/utf8_lenient_stream_decoder.sv
// Top level: lenient UTF-8 byte stream to codepoint decoder.
//
// in_ch carries one byte per item with string_last on the final byte of a
// string; out_ch carries codepoints (or raw bytes standing for themselves),
// the bytes each consumed, run_end on the last result of a byte and
// string_end on the final result of a string. Both are valid/ready channels.
// A byte lands in an input register, is decoded against the held sequence
// state and moves into a four-entry result buffer once that buffer is empty
// or handing out its last entry. Bytes are taken one per cycle while the
// receiver keeps pace; a byte that yields k results holds the buffer until
// all are taken, and a byte that only extends a sequence yields none. The
// input register keeps one byte waiting while results drain, so a stalled
// receiver backs up into in_ch.ready without losing or repeating anything.
// Reset drops any held lead and empties both registers; no clearing pass.
module utf8_lenient_stream_decoder import u8dec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);

  logic              in_v_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;

  logic              pend_r, pend_nxt;
  logic [BYTE_W-1:0] lead_r, lead_nxt;
  logic [USED_W-1:0] claim_r, claim_nxt;
  logic [1:0]        held_r, held_nxt;
  logic [PAY_W-1:0]  hp_r [2];

  res_t              buf_r [MAX_RES];
  logic [2:0]        cnt_r;

  res_t              res [MAX_RES];
  logic [2:0]        n;
  logic [2:0]        nm1;
  logic              hp_we;
  logic              move;
  logic              pop;

  assign pop  = (cnt_r != 3'd0) && out_ch.ready;
  assign move = in_v_r && ((cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready));
  assign in_ch.ready = !in_v_r || move;

  always_comb begin
    res       = '{default: '0};
    n         = 3'd0;
    nm1       = 3'd0;
    hp_we     = 1'b0;
    pend_nxt  = pend_r;
    lead_nxt  = lead_r;
    claim_nxt = claim_r;
    held_nxt  = held_r;
    if (pend_r && is_cont(byte_r) && ({1'b0, held_r} + 3'd2 >= claim_r)) begin
      res[0].bytes_used = claim_r;
      unique case (claim_r)
        LEN_2:   res[0].codepoint = {10'd0, lead_r[4:0] & LEAD2_MASK, byte_r[5:0]};
        LEN_3:   res[0].codepoint = {5'd0, lead_r[3:0] & LEAD3_MASK, hp_r[0],
                                     byte_r[5:0]};
        default: res[0].codepoint = {lead_r[2:0] & LEAD4_MASK, hp_r[0], hp_r[1],
                                     byte_r[5:0]};
      endcase
      n         = 3'd1;
      pend_nxt  = 1'b0;
      lead_nxt  = '0;
      claim_nxt = LEN_1;
      held_nxt  = 2'd0;
    end else if (pend_r && is_cont(byte_r) && !last_r) begin
      hp_we    = 1'b1;
      held_nxt = held_r + 2'd1;
    end else begin
      if (pend_r) begin
        res[0] = raw_res(lead_r);
        res[1] = raw_res({CONT_TAG[7:6], hp_r[0] & PAY_MASK});
        res[2] = raw_res({CONT_TAG[7:6], hp_r[1] & PAY_MASK});
        n      = 3'd1 + {1'b0, held_r};
        pend_nxt  = 1'b0;
        lead_nxt  = '0;
        claim_nxt = LEN_1;
        held_nxt  = 2'd0;
      end
      if (is_cont(byte_r) || claim_of(byte_r) == LEN_1 || last_r) begin
        res[n[1:0]] = raw_res(byte_r);
        n = n + 3'd1;
      end else begin
        pend_nxt  = 1'b1;
        lead_nxt  = byte_r;
        claim_nxt = claim_of(byte_r);
        held_nxt  = 2'd0;
      end
    end
    if (n != 3'd0) begin
      nm1 = n - 3'd1;
      res[nm1[1:0]].run_end    = 1'b1;
      res[nm1[1:0]].string_end = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      pend_r  <= 1'b0;
      lead_r  <= '0;
      claim_r <= LEN_1;
      held_r  <= 2'd0;
      cnt_r   <= 3'd0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (move) begin
        pend_r  <= pend_nxt;
        lead_r  <= lead_nxt;
        claim_r <= claim_nxt;
        held_r  <= held_nxt;
        cnt_r   <= n;
      end else if (pop) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.string_last;
    end
    if (move && hp_we) begin
      hp_r[held_r[0]] <= byte_r[5:0] & PAY_MASK;
    end
    if (move) begin
      buf_r <= res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  assign out_ch.valid      = (cnt_r != 3'd0);
  assign out_ch.codepoint  = buf_r[0].codepoint;
  assign out_ch.bytes_used = buf_r[0].bytes_used;
  assign out_ch.run_end    = buf_r[0].run_end;
  assign out_ch.string_end = buf_r[0].string_end;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result buffer count out of range");

  a_last_entry_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd1 |-> out_ch.run_end)
    else $error("final buffered result lacks run_end");

  a_string_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.string_end |-> out_ch.run_end)
    else $error("string_end without run_end");

  a_pending_shape: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (claim_r >= LEN_2) && ({1'b0, held_r} + 3'd2 <= claim_r))
    else $error("held sequence state inconsistent");

endmodule

>>> test/tb_top.sv
// Testbench for the lenient UTF-8 stream decoder: predicted codepoints checked per item.
`timescale 1ns / 1ps

module tb_top import u8dec_pkg::*; ();

  logic clk;
  logic rst_n;

  u8dec_in_if  byte_if ();
  u8dec_out_if cp_if ();

  utf8_lenient_stream_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_if.sink),
    .out_ch (cp_if.source)
  );

  // decoder state as predicted
  logic              lead_held;
  logic [BYTE_W-1:0] lead_byte;
  logic [USED_W-1:0] lead_len;
  int                cont_cnt;
  logic [PAY_W-1:0]  cont_pay [2];

  res_t due_cps [$];

  bit idle_on;
  int rx_hold;
  int n_bytes;
  int n_cps;
  int n_errs;
  int n_reported;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [USED_W-1:0] lead_claim(input logic [BYTE_W-1:0] b);
    if (b >= 8'hc0 && b <= 8'hdf) return LEN_2;
    if (b >= 8'he0 && b <= 8'hef) return LEN_3;
    if (b >= 8'hf0 && b <= 8'hf7) return LEN_4;
    return LEN_1;
  endfunction

  function automatic res_t raw_cp(input logic [BYTE_W-1:0] b);
    res_t r;
    r.codepoint  = CP_W'(b);
    r.bytes_used = LEN_1;
    r.run_end    = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    res_t            batch [$];
    res_t            r;
    logic            cont;
    logic [CP_W-1:0] v;
    int              i;
    cont = (b & CONT_MASK) == CONT_TAG;
    if (lead_held && cont) begin
      if (cont_cnt + 2 >= int'(lead_len)) begin
        case (lead_len)
          LEN_2:   v = CP_W'(lead_byte[4:0] & LEAD2_MASK);
          LEN_3:   v = CP_W'(lead_byte[3:0] & LEAD3_MASK);
          default: v = CP_W'(lead_byte[2:0] & LEAD4_MASK);
        endcase
        for (i = 0; i < cont_cnt; i++) v = (v << PAY_W) | CP_W'(cont_pay[i] & PAY_MASK);
        v = (v << PAY_W) | CP_W'(b[5:0] & PAY_MASK);
        r = raw_cp(8'h00);
        r.codepoint  = v;
        r.bytes_used = lead_len;
        batch.push_back(r);
        lead_held = 1'b0;
        lead_len  = LEN_1;
        cont_cnt  = 0;
      end else if (last) begin
        batch.push_back(raw_cp(lead_byte));
        for (i = 0; i < cont_cnt; i++) batch.push_back(raw_cp(CONT_TAG | BYTE_W'(cont_pay[i])));
        batch.push_back(raw_cp(b));
        lead_held = 1'b0;
        lead_len  = LEN_1;
        cont_cnt  = 0;
      end else begin
        cont_pay[cont_cnt % 2] = b[5:0] & PAY_MASK;
        cont_cnt++;
      end
    end else begin
      if (lead_held) begin
        batch.push_back(raw_cp(lead_byte));
        for (i = 0; i < cont_cnt; i++) batch.push_back(raw_cp(CONT_TAG | BYTE_W'(cont_pay[i])));
        lead_held = 1'b0;
        lead_len  = LEN_1;
        cont_cnt  = 0;
      end
      if (lead_claim(b) == LEN_1 || last) begin
        batch.push_back(raw_cp(b));
      end else begin
        lead_held = 1'b1;
        lead_byte = b;
        lead_len  = lead_claim(b);
        cont_cnt  = 0;
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_end    = 1'b1;
      batch[batch.size()-1].string_end = last;
    end
    foreach (batch[j]) due_cps.push_back(batch[j]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = idle_on ? ($urandom_range(0, 1) ? 0 : $urandom_range(1, 17)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid       = 1'b1;
    byte_if.in_byte     = b;
    byte_if.string_last = last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    decode_byte(b, last);
    n_bytes++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    byte_if.valid = 1'b0;
    while (due_cps.size() != 0) @(posedge clk);
  endtask

  task automatic check_cp();
    res_t got;
    res_t want;
    got.codepoint  = cp_if.codepoint;
    got.bytes_used = cp_if.bytes_used;
    got.run_end    = cp_if.run_end;
    got.string_end = cp_if.string_end;
    n_cps++;
    if (due_cps.size() == 0) begin
      n_errs++;
      if (n_reported < 10)
        $display("unexpected result: cp=%h used=%0d run_end=%b string_end=%b",
                 got.codepoint, got.bytes_used, got.run_end, got.string_end);
      n_reported++;
    end else begin
      want = due_cps.pop_front();
      if (got.codepoint !== want.codepoint || got.bytes_used !== want.bytes_used ||
          got.run_end !== want.run_end || got.string_end !== want.string_end) begin
        n_errs++;
        if (n_reported < 10)
          $display("mismatch: exp cp=%h used=%0d run=%b str=%b, got cp=%h used=%0d run=%b str=%b",
                   want.codepoint, want.bytes_used, want.run_end, want.string_end,
                   got.codepoint, got.bytes_used, got.run_end, got.string_end);
        n_reported++;
      end
    end
  endtask

  // result side: random stall per item, long hold-off on request
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        n       = rx_hold;
        rx_hold = 0;
      end else begin
        n = idle_on ? ($urandom_range(0, 1) ? 0 : $urandom_range(1, 17)) : 0;
      end
      if (n > 0) begin
        cp_if.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      cp_if.ready = 1'b1;
      @(posedge clk);
      while (!cp_if.valid && rx_hold == 0) @(posedge clk);
      if (cp_if.valid) check_cp();
    end
  end

  task automatic send_bytes(input logic [BYTE_W-1:0] bs [$], input logic last);
    foreach (bs[i]) send_byte(bs[i], last && (i == bs.size() - 1));
  endtask

  function automatic logic [BYTE_W-1:0] lead_of(input int len);
    case (len)
      2:       return BYTE_W'($urandom_range(8'hc0, 8'hdf));
      3:       return BYTE_W'($urandom_range(8'he0, 8'hef));
      4:       return BYTE_W'($urandom_range(8'hf0, 8'hf7));
      default: return BYTE_W'($urandom_range(8'h00, 8'h7f));
    endcase
  endfunction

  // one string: mostly whole sequences, some truncated ones and raw noise
  task automatic send_string();
    logic [BYTE_W-1:0] s [$];
    int nchar;
    int sel;
    int len;
    int nc;
    nchar = $urandom_range(1, 6);
    for (int c = 0; c < nchar; c++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        len = $urandom_range(1, 4);
        s.push_back(lead_of(len));
        for (int k = 1; k < len; k++) s.push_back(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
      end else if (sel < 9) begin
        len = $urandom_range(2, 4);
        nc  = $urandom_range(0, len - 2);
        s.push_back(lead_of(len));
        for (int k = 0; k < nc; k++) s.push_back(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
      end else begin
        s.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end
    send_bytes(s, 1'b1);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_bytes('{8'h00}, 1'b0);
    send_bytes('{8'h7f}, 1'b1);
    send_bytes('{8'hc3, 8'ha9}, 1'b0);
    send_bytes('{8'he2, 8'h82, 8'hac}, 1'b0);
    send_bytes('{8'hf7, 8'hbf, 8'hbf, 8'hbf}, 1'b1);
    // broken sequences
    send_bytes('{8'he2, 8'h41}, 1'b0);
    send_bytes('{8'hf0, 8'h9f, 8'h98, 8'h41}, 1'b1);
    // string ends short
    send_bytes('{8'he2, 8'h82}, 1'b1);
    // claiming lead as last byte
    send_bytes('{8'hc3}, 1'b1);
    // stray continuations, then bytes that claim no sequence
    send_bytes('{8'h80, 8'hbf}, 1'b0);
    send_bytes('{8'hff, 8'hf8}, 1'b1);
  endtask

  task automatic test_random(input int target, input bit idling);
    int start;
    idle_on = idling;
    start   = n_bytes;
    while (n_bytes - start < target) send_string();
  endtask

  task automatic test_backpressure();
    int start;
    idle_on = 1'b0;
    rx_hold = 80;
    start   = n_bytes;
    while (n_bytes - start < 40) send_string();
  endtask

  initial begin
    int guard;
    rst_n               = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.in_byte     = '0;
    byte_if.string_last = 1'b0;
    cp_if.ready         = 1'b0;
    lead_held           = 1'b0;
    lead_byte           = '0;
    lead_len            = LEN_1;
    cont_cnt            = 0;
    cont_pay[0]         = '0;
    cont_pay[1]         = '0;
    idle_on             = 1'b1;
    rx_hold             = 0;
    n_bytes             = 0;
    n_cps               = 0;
    n_errs              = 0;
    n_reported          = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drain();
    test_random(250, 1'b1);
    test_random(60, 1'b0);
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random(20, 1'b1);

    @(negedge clk);
    byte_if.valid = 1'b0;
    guard = 0;
    while (due_cps.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (due_cps.size() != 0) begin
      n_errs += due_cps.size();
      $display("%0d expected results never arrived", due_cps.size());
    end
    $display("sent %0d bytes (directed, random strings, no-idle and back-pressure runs)",
             n_bytes);
    $display("checked %0d results, %0d errors", n_cps, n_errs);
    if (n_errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/u8dec_pkg.sv
sv/u8dec_if.sv
sv/utf8_lenient_stream_decoder.sv
test/tb_top.sv
